@@ src/murmur2_hash32_core_macros.svh @@
// assertion macros for the murmur2 hash core
// needs a clock named clk and a reset named rst in the including module
`ifndef MURMUR2_HASH32_CORE_MACROS_SVH
`define MURMUR2_HASH32_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MMH2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define MMH2_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/mmh2_pkg.sv @@
// constants, sequencer codes and the tail mask for the murmur2 hash core
// no dependencies
`default_nettype none

package mmh2_pkg;

  localparam logic [31:0] MIX_MUL  = 32'h5bd1e995;
  localparam int unsigned WordShr  = 24;
  localparam int unsigned FinShrA  = 13;
  localparam int unsigned FinShrB  = 15;

  typedef logic [2:0] state_t;

  localparam state_t S_IDLE = 3'd0;
  localparam state_t S_K1   = 3'd1;
  localparam state_t S_K2   = 3'd2;
  localparam state_t S_H    = 3'd3;
  localparam state_t S_T    = 3'd4;
  localparam state_t S_A    = 3'd5;

  // bytes kept from a short last word
  function automatic logic [31:0] tail_mask(input logic [1:0] n);
    logic [31:0] m;
    unique case (n)
      2'd0: m = 32'h0000_0000;
      2'd1: m = 32'h0000_00ff;
      2'd2: m = 32'h0000_ffff;
      2'd3: m = 32'h00ff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/murmur2_hash32_core.sv @@
// murmur2 32-bit hash core: sequencer around one shared 32x32 multiplier
// depends on mmh2_pkg and murmur2_hash32_core_macros.svh
//
// Hashes a byte message delivered as little-endian 32-bit words. A word is
// taken when in_valid is high and in_stall low; the first word also samples
// seed and msg_length. Every multiply goes through a single 32x32 multiplier,
// one multiply per cycle while the avalanche step is not held, so a full word
// is the transfer followed by three multiplies. A last word of four bytes
// takes those three, one with one to three tail bytes a single tail multiply
// and an empty one none; each then ends in the avalanche multiply. The digest
// sits in an output register, so new words are taken while it waits; the
// avalanche step waits only if that register still holds an earlier digest.
`default_nettype none

module murmur2_hash32_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        first_word,
  input  wire logic        last_word,
  input  wire logic [31:0] seed,
  input  wire logic [31:0] msg_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      hash
);

`include "murmur2_hash32_core_macros.svh"

  mmh2_pkg::state_t state;
  logic             in_message;
  logic [31:0]      h;
  logic [31:0]      k;
  logic [31:0]      w;
  logic [1:0]       cnt;
  logic             last;

  logic             in_xfer;
  logic             out_xfer;
  logic             take;
  logic [31:0]      mul_a;
  logic [31:0]      mul_p;
  logic [31:0]      fin;
  logic             fin_go;

  assign in_stall = (state != mmh2_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign take     = in_xfer && (first_word || in_message);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      mmh2_pkg::S_K1:  mul_a = w;
      mmh2_pkg::S_K2:  mul_a = k;
      mmh2_pkg::S_H:   mul_a = h;
      mmh2_pkg::S_T:   mul_a = h ^ (w & mmh2_pkg::tail_mask(cnt));
      mmh2_pkg::S_A:   mul_a = h ^ (h >> mmh2_pkg::FinShrA);
      default:         mul_a = h;
    endcase
  end

  assign mul_p  = mul_a * mmh2_pkg::MIX_MUL;
  assign fin    = mul_p ^ (mul_p >> mmh2_pkg::FinShrB);
  assign fin_go = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mmh2_pkg::S_IDLE;
      in_message <= 1'b0;
      out_valid  <= 1'b0;
      h          <= '0;
    end else begin
      if (state == mmh2_pkg::S_A && fin_go) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mmh2_pkg::S_IDLE: begin
          if (take) begin
            if (first_word) begin
              h <= seed ^ msg_length;
            end
            in_message <= !last_word;
            if (!last_word || byte_count[2]) begin
              state <= mmh2_pkg::S_K1;
            end else if (byte_count[1:0] == 2'd0) begin
              state <= mmh2_pkg::S_A;
            end else begin
              state <= mmh2_pkg::S_T;
            end
          end
        end
        mmh2_pkg::S_K1: begin
          k     <= mul_p ^ (mul_p >> mmh2_pkg::WordShr);
          state <= mmh2_pkg::S_K2;
        end
        mmh2_pkg::S_K2: begin
          k     <= mul_p;
          state <= mmh2_pkg::S_H;
        end
        mmh2_pkg::S_H: begin
          h     <= mul_p ^ k;
          state <= last ? mmh2_pkg::S_A : mmh2_pkg::S_IDLE;
        end
        mmh2_pkg::S_T: begin
          h     <= mul_p;
          state <= mmh2_pkg::S_A;
        end
        mmh2_pkg::S_A: begin
          if (fin_go) begin
            h     <= fin;
            state <= mmh2_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mmh2_pkg::S_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      w    <= data_word;
      cnt  <= byte_count[1:0];
      last <= last_word;
    end
    if (state == mmh2_pkg::S_A && fin_go) begin
      hash <= fin;
    end
  end

  `MMH2_ASSERT(a_out_from_final, $rose(out_valid) |-> $past(state) == mmh2_pkg::S_A,
    "digest raised without the avalanche step")
  `MMH2_ASSERT(a_full_word_len,
    take && !last_word |-> ##4 state == mmh2_pkg::S_IDLE,
    "mixing word did not finish in four cycles")
  `MMH2_ASSERT(a_last_ends_msg, take && last_word |=> !in_message,
    "message still open after its last word")
  `MMH2_ASSERT(a_empty_to_final,
    take && last_word && byte_count == 3'd0 |=> state == mmh2_pkg::S_A,
    "empty last word did not go straight to the avalanche")
  `MMH2_ASSERT_ALWAYS(a_reset_idle, rst |=> state == mmh2_pkg::S_IDLE && !out_valid,
    "sequencer not idle after reset")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for murmur2_hash32_core: random and directed word streams checked
// against a digest scoreboard; depends on mmh2_pkg and the core rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned WordTarget = 500;
  localparam int unsigned QuietFrom  = 440;

  class digest_board;
    logic [31:0] run_hash;
    bit          busy;
    logic [31:0] pending_digests[$];
    int unsigned errors;

    function new();
      run_hash = '0;
      busy     = 1'b0;
      errors   = 0;
    endfunction

    // returns 1 when the word is hashed, 0 when it is ignored
    function bit take_word(logic [31:0] data, logic [2:0] cnt, logic fw, logic lw,
                           logic [31:0] sd, logic [31:0] len);
      logic [31:0] h;
      logic [31:0] k;
      if (fw) begin
        run_hash = sd ^ len;
        busy     = 1'b1;
      end else if (!busy) begin
        return 1'b0;
      end
      h = run_hash;
      if (!lw || cnt >= 3'd4) begin
        k = data * mmh2_pkg::MIX_MUL;
        k = k ^ (k >> mmh2_pkg::WordShr);
        k = k * mmh2_pkg::MIX_MUL;
        h = (h * mmh2_pkg::MIX_MUL) ^ k;
      end else if (cnt != 3'd0) begin
        h = h ^ (data & ~(32'hffff_ffff << (8 * cnt)));
        h = h * mmh2_pkg::MIX_MUL;
      end
      if (!lw) begin
        run_hash = h;
        return 1'b1;
      end
      h = h ^ (h >> mmh2_pkg::FinShrA);
      h = h * mmh2_pkg::MIX_MUL;
      h = h ^ (h >> mmh2_pkg::FinShrB);
      run_hash = h;
      busy     = 1'b0;
      pending_digests.push_back(h);
      return 1'b1;
    endfunction

    function void check_digest(logic [31:0] got);
      logic [31:0] want;
      if (pending_digests.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_digests.pop_front();
        if (got !== want) begin
          $display("%0t: hash mismatch, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [31:0] data_word  = '0;
  logic [2:0]  byte_count = '0;
  logic        first_word = 1'b0;
  logic        last_word  = 1'b0;
  logic [31:0] seed       = '0;
  logic [31:0] msg_length = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] hash;

  digest_board digests = new();
  int unsigned hashed_words = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;

  murmur2_hash32_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .first_word (first_word),
    .last_word  (last_word),
    .seed       (seed),
    .msg_length (msg_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash       (hash)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int unsigned run;
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 18);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (run) @(posedge clk);
      end
    end
  end

  // a result transfer happens at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) digests.check_digest(hash);
  end

  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic fw,
                           input logic lw, input logic [31:0] sd, input logic [31:0] len);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= data;
    byte_count <= cnt;
    first_word <= fw;
    last_word  <= lw;
    seed       <= sd;
    msg_length <= len;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    if (digests.take_word(data, cnt, fw, lw, sd, len)) hashed_words++;
    @(posedge clk);
  endtask

  task automatic send_message(input int unsigned nbytes, input logic [31:0] sd,
                              input logic [31:0] len);
    int unsigned nwords;
    logic [2:0]  cnt;
    nwords = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
    for (int unsigned i = 0; i < nwords; i++) begin
      if (i + 1 < nwords) begin
        cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      end else if (nbytes == 0) begin
        cnt = 3'd0;
      end else if (nbytes % 4 != 0) begin
        cnt = 3'(nbytes % 4);
      end else begin
        cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7)) : 3'd4;
      end
      send_word($urandom, cnt, i == 0, i + 1 == nwords,
                (i == 0) ? sd : $urandom, (i == 0) ? len : $urandom);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digests.pending_digests.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned nbytes;
    logic [31:0] sd;
    logic [31:0] len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: stray word, empty messages, tails, odd counts, restart, bad length
    send_word(32'hffff_ffff, 3'd7, 1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_word(32'h0, 3'd0, 1'b1, 1'b1, 32'h0, 32'h0);
    send_word(32'hffff_ffff, 3'd0, 1'b1, 1'b1, 32'hffff_ffff, 32'h0);
    send_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'hffff_ffff, 32'd1);
    send_word(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 32'h1234_5678, 32'd2);
    send_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'h0, 32'd3);
    send_word(32'h0, 3'd4, 1'b1, 1'b1, 32'h0, 32'd4);
    send_word(32'hffff_ffff, 3'd7, 1'b1, 1'b1, 32'hffff_ffff, 32'd4);
    send_word(32'ha5a5_5a5a, 3'd0, 1'b1, 1'b0, 32'hdead_beef, 32'd8);
    send_word(32'h5a5a_a5a5, 3'd4, 1'b0, 1'b1, 32'h0, 32'h0);
    send_word(32'h0102_0304, 3'd4, 1'b1, 1'b0, 32'h0bad_f00d, 32'd12);
    send_word(32'h0506_0708, 3'd4, 1'b1, 1'b0, 32'hffff_ffff, 32'd5);
    send_word(32'h0000_0009, 3'd1, 1'b0, 1'b1, 32'h0, 32'h0);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h8000_0001, 32'hffff_ffff);
    send_word(32'h8000_0000, 3'd6, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(32'h7fff_ffff, 3'd4, 1'b0, 1'b1, 32'h0, 32'h0);
    send_word(32'hcafe_babe, 3'd5, 1'b1, 1'b1, 32'h0, 32'hffff_ffff);
    send_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_word(32'h1234_5678, 3'd2, 1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff);

    // hold the sender off until every digest is out
    wait_drained();

    while (hashed_words < WordTarget) begin
      if (hashed_words >= QuietFrom) quiet = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'($urandom_range(0, 1)),
                  $urandom, $urandom);
      end else if (pick == 1) begin
        // message cut short, the next first transfer restarts the hash
        repeat ($urandom_range(1, 3)) send_word($urandom, 3'd4, 1'b1, 1'b0, $urandom, $urandom);
      end else if (pick == 2) begin
        if (!quiet) wait_drained();
      end else begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
        case ($urandom_range(0, 7))
          0:       sd = 32'h0;
          1:       sd = 32'hffff_ffff;
          default: sd = $urandom;
        endcase
        len = ($urandom_range(0, 5) == 0) ? $urandom : nbytes;
        send_message(nbytes, sd, len);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (digests.errors == 0 && digests.pending_digests.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/mmh2_pkg.sv
src/murmur2_hash32_core.sv
dv/tb_top.sv
